@@ src/region_box_blur_3x3_defines.svh @@
// Assertion macros for the region box blur block.
`ifndef REGION_BOX_BLUR_3X3_DEFINES_SVH
`define REGION_BOX_BLUR_3X3_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RBB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbb: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbb: next-cycle check failed");

`endif

@@ src/rbb_pkg.sv @@
// Shared types, constants and widths of the region box blur block.
package rbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3);

  localparam int CFG_DIM_W  = 12;
  localparam int CFG_POS_W  = 11;
  localparam int CFG_HALF_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;

  // Bound arithmetic: region edges, dimensions and emitted positions plus one.
  localparam int BND_A = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;
  localparam int BND_W = (BND_A > CFG_DIM_W) ? BND_A : CFG_DIM_W;

  localparam int CH_W   = 8;
  localparam int POS_W  = 11;
  localparam int SUM_W  = 12;
  localparam int RECIP_W = 13;
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam int MIN_DIM     = 3;
  localparam int STEP_PIXELS = 50;
  localparam int DIV9_RECIP  = 7282;
  localparam int DIV9_SHIFT  = 16;

  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int RST_CENTER = 0;
  localparam int RST_HALF   = 1;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CENTER_COL   = 3'd2,
    REG_CENTER_ROW   = 3'd3,
    REG_HALF_SIZE    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t up;
    pixel_t lo;
    pixel_t cur;
  } column_t;

  typedef struct packed {
    logic [BND_W-1:0] w;
    logic [BND_W-1:0] h;
    logic [BND_W-1:0] w_m1;
    logic [BND_W-1:0] h_m1;
    logic [BND_W-1:0] left;
    logic [BND_W-1:0] top;
    logic [BND_W-1:0] right;
    logic [BND_W-1:0] bottom;
  } geom_t;

  typedef struct packed {
    logic             emit;
    logic             blur;
    logic             frame_end;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } item_meta_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

endpackage

@@ src/region_box_blur_3x3.sv @@
// Top level of the region box blur: stage control, mean, output register.
//
// Streams RGB pixels in raster order on the in_ channel and returns one
// pixel per position on the out_ channel, one row plus one pixel late.
// Drain transactions (opcode high) push a zero pixel so the frame tail
// flushes; width+1 drains after the last pixel empty the frame. frame_start
// on a pixel restarts the position counters.
// One transaction per clock is accepted while in_tready is high. A result
// passes line memory read, window shift and window sum, then divide-by-nine
// and select into out_tdata. Inside the configured region the nine-pixel
// mean replaces each channel. The cfg_ channel writes registers by index;
// it is always ready. The user must write it only while the stream is idle;
// the block does not enforce this. A write applies to the next input. Reset
// clears the counters, window and stage valids; the line memories are not
// cleared. When out_tready is low the output holds and the stages behind it
// fill, then in_tready drops; nothing is lost or repeated.
`include "region_box_blur_3x3_defines.svh"

module region_box_blur_3x3 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rbb_pkg::IN_TDATA_W-1:0]    in_tdata,   // blue, green, red
  input  logic [rbb_pkg::IN_TUSER_W-1:0]    in_tuser,   // opcode, frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rbb_pkg::OUT_TDATA_W-1:0]   out_tdata,  // blue, green, red, col, row
  output logic                              out_tlast,
  output logic [rbb_pkg::OUT_TUSER_W-1:0]   out_tuser,  // was_blurred
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rbb_pkg::geom_t            geom;
  rbb_pkg::item_meta_t       meta_in;
  rbb_pkg::item_meta_t       s1_meta_r;
  rbb_pkg::item_meta_t       s2_meta_r;
  rbb_pkg::item_meta_t       s3_meta_r;
  rbb_pkg::item_meta_t       o_meta_r;
  rbb_pkg::column_t          column_q;
  rbb_pkg::sums_t            sums_r;
  rbb_pkg::pixel_t           center_r;
  rbb_pkg::pixel_t           pix_in;
  rbb_pkg::pixel_t           o_pix_r;
  rbb_pkg::pixel_t           o_pix_nxt;
  logic [rbb_pkg::COL_W-1:0] rd_col;
  logic                      accept;
  logic                      drain;
  logic                      start;
  logic                      s1_v_r;
  logic                      s2_v_r;
  logic                      s3_v_r;
  logic                      o_valid_r;
  logic                      o_ready_in;
  logic                      s3_en;
  logic                      s2_go;
  logic                      s2_en;
  logic                      s1_go;
  logic                      s1_en;
  logic                      s3_load;

  function automatic logic [rbb_pkg::CH_W-1:0] mean9(input logic [rbb_pkg::SUM_W-1:0] s);
    logic [rbb_pkg::PROD_W-1:0] p;
    p = rbb_pkg::PROD_W'(s) * rbb_pkg::PROD_W'(rbb_pkg::DIV9_RECIP);
    return p[rbb_pkg::DIV9_SHIFT +: rbb_pkg::CH_W];
  endfunction

  assign drain  = (rbb_pkg::opcode_e'(in_tuser[0]) == rbb_pkg::OP_DRAIN);
  assign start  = in_tuser[1];
  assign pix_in = drain ? '0 : rbb_pkg::pixel_t'(in_tdata);

  assign o_ready_in = !o_valid_r || out_tready;
  assign s3_en      = !s3_v_r || o_ready_in;
  assign s2_go      = s2_v_r && (!s2_meta_r.emit || s3_en);
  assign s2_en      = !s2_v_r || s2_go;
  assign s1_go      = s1_v_r && s2_en;
  assign s1_en      = !s1_v_r || s1_go;
  assign s3_load    = s2_go && s2_meta_r.emit;
  assign in_tready  = s1_en;
  assign accept     = in_tvalid && in_tready;

  rbb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom_r    (geom)
  );

  rbb_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .drain  (drain),
    .start  (start),
    .geom   (geom),
    .col    (rd_col),
    .meta   (meta_in)
  );

  rbb_line_buf u_line_buf (
    .clk      (clk),
    .rd_en    (accept),
    .col      (rd_col),
    .pix      (pix_in),
    .commit   (s1_go),
    .column_q (column_q)
  );

  rbb_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_go),
    .column   (column_q),
    .sum_en   (s3_load),
    .sums_r   (sums_r),
    .center_r (center_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= accept;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_en) begin
        s3_v_r <= s3_load;
      end
      if (o_ready_in) begin
        o_valid_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta_in;
    end
    if (s1_go) begin
      s2_meta_r <= s1_meta_r;
    end
    if (s3_load) begin
      s3_meta_r <= s2_meta_r;
    end
    if (o_ready_in && s3_v_r) begin
      o_meta_r <= s3_meta_r;
      o_pix_r  <= o_pix_nxt;
    end
  end

  always_comb begin
    if (s3_meta_r.blur) begin
      o_pix_nxt.red   = mean9(sums_r.red);
      o_pix_nxt.green = mean9(sums_r.green);
      o_pix_nxt.blue  = mean9(sums_r.blue);
    end else begin
      o_pix_nxt = center_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = rbb_pkg::OUT_TDATA_W'({o_meta_r.row, o_meta_r.col, o_pix_r});
  assign out_tlast  = o_meta_r.frame_end;
  assign out_tuser  = o_meta_r.blur;

  `RBB_ASSERT_IMPL(a_no_blur_on_frame_end, out_tvalid, !(out_tlast && out_tuser[0]))
  `RBB_ASSERT_IMPL(a_blur_off_edges, out_tvalid && out_tuser[0], |o_meta_r.col && |o_meta_r.row)
  `RBB_ASSERT_IMPL(a_stall_from_sink, !in_tready, out_tvalid && !out_tready)
  `RBB_ASSERT_NEXT(a_out_drains, out_tvalid && out_tready && !s3_v_r, !out_tvalid)

endmodule

@@ src/rbb_cfg.sv @@
// Configuration registers and derived frame and region geometry.
module rbb_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rbb_pkg::geom_t                  geom_r
);

  logic [rbb_pkg::CFG_DIM_W-1:0]  width_r;
  logic [rbb_pkg::CFG_DIM_W-1:0]  height_r;
  logic [rbb_pkg::CFG_POS_W-1:0]  ccol_r;
  logic [rbb_pkg::CFG_POS_W-1:0]  crow_r;
  logic [rbb_pkg::CFG_HALF_W-1:0] half_r;
  logic [rbb_pkg::CFG_DIM_W-1:0]  width_nxt;
  logic [rbb_pkg::CFG_DIM_W-1:0]  height_nxt;
  logic [rbb_pkg::CFG_POS_W-1:0]  ccol_nxt;
  logic [rbb_pkg::CFG_POS_W-1:0]  crow_nxt;
  logic [rbb_pkg::CFG_HALF_W-1:0] half_nxt;
  rbb_pkg::geom_t                 geom_nxt;

  function automatic logic [rbb_pkg::BND_W-1:0] clamp_dim(
    input logic [rbb_pkg::CFG_DIM_W-1:0] v,
    input int                            maxv
  );
    logic [rbb_pkg::BND_W-1:0] res;
    if (v < rbb_pkg::CFG_DIM_W'(rbb_pkg::MIN_DIM)) begin
      res = rbb_pkg::BND_W'(rbb_pkg::MIN_DIM);
    end else if (32'(v) > maxv) begin
      res = rbb_pkg::BND_W'(maxv);
    end else begin
      res = rbb_pkg::BND_W'(v);
    end
    return res;
  endfunction

  function automatic rbb_pkg::geom_t geom_calc(
    input logic [rbb_pkg::CFG_DIM_W-1:0]  wv,
    input logic [rbb_pkg::CFG_DIM_W-1:0]  hv,
    input logic [rbb_pkg::CFG_POS_W-1:0]  cc,
    input logic [rbb_pkg::CFG_POS_W-1:0]  cr,
    input logic [rbb_pkg::CFG_HALF_W-1:0] hs
  );
    rbb_pkg::geom_t            g;
    logic [rbb_pkg::BND_W-1:0] range;
    logic [rbb_pkg::BND_W-1:0] ccb;
    logic [rbb_pkg::BND_W-1:0] crb;
    logic [rbb_pkg::BND_W-1:0] rgt;
    logic [rbb_pkg::BND_W-1:0] bot;
    g.w    = clamp_dim(wv, rbb_pkg::MAX_WIDTH);
    g.h    = clamp_dim(hv, rbb_pkg::MAX_HEIGHT);
    g.w_m1 = g.w - rbb_pkg::BND_W'(1);
    g.h_m1 = g.h - rbb_pkg::BND_W'(1);
    range  = rbb_pkg::BND_W'(hs) * rbb_pkg::BND_W'(rbb_pkg::STEP_PIXELS);
    ccb    = rbb_pkg::BND_W'(cc);
    crb    = rbb_pkg::BND_W'(cr);
    g.left = (ccb >= range) ? ccb - range : '0;
    g.top  = (crb >= range) ? crb - range : '0;
    rgt    = ccb + range;
    bot    = crb + range;
    g.right  = (rgt > g.w_m1) ? g.w_m1 : rgt;
    g.bottom = (bot > g.h_m1) ? g.h_m1 : bot;
    return g;
  endfunction

  assign cfg_ready = 1'b1;

  // Geometry is registered together with the write so the next transaction sees it.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    ccol_nxt   = ccol_r;
    crow_nxt   = crow_r;
    half_nxt   = half_r;
    if (cfg_valid && cfg_ready) begin
      case (rbb_pkg::cfg_reg_e'(cfg_index))
        rbb_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        rbb_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_data;
        rbb_pkg::REG_CENTER_COL:   ccol_nxt   = cfg_data[rbb_pkg::CFG_POS_W-1:0];
        rbb_pkg::REG_CENTER_ROW:   crow_nxt   = cfg_data[rbb_pkg::CFG_POS_W-1:0];
        rbb_pkg::REG_HALF_SIZE:    half_nxt   = cfg_data[rbb_pkg::CFG_HALF_W-1:0];
        default: ;
      endcase
    end
    geom_nxt = geom_calc(width_nxt, height_nxt, ccol_nxt, crow_nxt, half_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rbb_pkg::CFG_DIM_W'(rbb_pkg::RST_WIDTH);
      height_r <= rbb_pkg::CFG_DIM_W'(rbb_pkg::RST_HEIGHT);
      ccol_r   <= rbb_pkg::CFG_POS_W'(rbb_pkg::RST_CENTER);
      crow_r   <= rbb_pkg::CFG_POS_W'(rbb_pkg::RST_CENTER);
      half_r   <= rbb_pkg::CFG_HALF_W'(rbb_pkg::RST_HALF);
      geom_r   <= geom_calc(rbb_pkg::CFG_DIM_W'(rbb_pkg::RST_WIDTH),
                            rbb_pkg::CFG_DIM_W'(rbb_pkg::RST_HEIGHT),
                            rbb_pkg::CFG_POS_W'(rbb_pkg::RST_CENTER),
                            rbb_pkg::CFG_POS_W'(rbb_pkg::RST_CENTER),
                            rbb_pkg::CFG_HALF_W'(rbb_pkg::RST_HALF));
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      ccol_r   <= ccol_nxt;
      crow_r   <= crow_nxt;
      half_r   <= half_nxt;
      geom_r   <= geom_nxt;
    end
  end

endmodule

@@ src/rbb_scan.sv @@
// Raster position counters and per-transaction emission and blur decision.
module rbb_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        drain,
  input  logic                        start,
  input  rbb_pkg::geom_t              geom,
  output logic [rbb_pkg::COL_W-1:0]   col,
  output rbb_pkg::item_meta_t         meta
);

  logic [rbb_pkg::COL_W-1:0] col_cnt_r;
  logic [rbb_pkg::COL_W-1:0] col_cnt_nxt;
  logic [rbb_pkg::ROW_W-1:0] row_cnt_r;
  logic [rbb_pkg::ROW_W-1:0] row_cnt_nxt;
  logic [rbb_pkg::ROW_W-1:0] row;
  logic [rbb_pkg::BND_W-1:0] cb;
  logic [rbb_pkg::BND_W-1:0] rb;
  logic [rbb_pkg::BND_W-1:0] c1;
  logic [rbb_pkg::BND_W-1:0] exb;
  logic [rbb_pkg::BND_W-1:0] eyb;
  logic                      restart;
  logic                      valid;

  always_comb begin
    restart = !drain && start;
    col     = restart ? '0 : col_cnt_r;
    row     = restart ? '0 : row_cnt_r;
    cb      = rbb_pkg::BND_W'(col);
    rb      = rbb_pkg::BND_W'(row);

    if (col != '0) begin
      exb   = cb - rbb_pkg::BND_W'(1);
      eyb   = rb - rbb_pkg::BND_W'(1);
      valid = (rb >= rbb_pkg::BND_W'(1)) && (eyb < geom.h);
    end else begin
      exb   = geom.w_m1;
      eyb   = rb - rbb_pkg::BND_W'(2);
      valid = (rb >= rbb_pkg::BND_W'(2)) && (eyb < geom.h);
    end

    meta.emit      = valid;
    meta.blur      = (exb >= rbb_pkg::BND_W'(1)) && (eyb >= rbb_pkg::BND_W'(1)) &&
                     (exb >= geom.left) && (eyb >= geom.top) &&
                     (exb + rbb_pkg::BND_W'(1) <= geom.right) &&
                     (eyb + rbb_pkg::BND_W'(1) <= geom.bottom);
    meta.frame_end = (exb == geom.w_m1) && (eyb == geom.h_m1);
    meta.col       = rbb_pkg::POS_W'(exb);
    meta.row       = rbb_pkg::POS_W'(eyb);

    c1 = cb + rbb_pkg::BND_W'(1);
    if (c1 >= geom.w) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (rb < geom.h + rbb_pkg::BND_W'(2)) ?
                    row + rbb_pkg::ROW_W'(1) : row;
    end else begin
      col_cnt_nxt = rbb_pkg::COL_W'(c1);
      row_cnt_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

@@ src/rbb_line_buf.sv @@
// Two line memories giving the column of three pixels above and at the input.
module rbb_line_buf (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [rbb_pkg::COL_W-1:0] col,
  input  rbb_pkg::pixel_t           pix,
  input  logic                      commit,
  output rbb_pkg::column_t          column_q
);

  rbb_pkg::pixel_t           upper_mem [rbb_pkg::MAX_WIDTH];
  rbb_pkg::pixel_t           lower_mem [rbb_pkg::MAX_WIDTH];
  logic [rbb_pkg::COL_W-1:0] col_r;
  logic                      fwd;

  // Upper row is written back one stage late; bypass when the next read hits it.
  assign fwd = commit && (col == col_r);

  always_ff @(posedge clk) begin
    if (commit) begin
      upper_mem[col_r] <= column_q.lo;
    end
    if (rd_en) begin
      column_q.up  <= fwd ? column_q.lo : upper_mem[col];
      column_q.lo  <= lower_mem[col];
      column_q.cur <= pix;
      lower_mem[col] <= pix;
      col_r <= col;
    end
  end

endmodule

@@ src/rbb_window.sv @@
// 3x3 pixel window and registered per-channel sums of its nine cells.
module rbb_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  rbb_pkg::column_t  column,
  input  logic              sum_en,
  output rbb_pkg::sums_t    sums_r,
  output rbb_pkg::pixel_t   center_r
);

  rbb_pkg::pixel_t win_r [3][3];
  rbb_pkg::sums_t  sums_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= column.up;
      win_r[1][2] <= column.lo;
      win_r[2][2] <= column.cur;
    end
  end

  always_comb begin
    sums_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sums_nxt.red   = sums_nxt.red   + rbb_pkg::SUM_W'(win_r[i][j].red);
        sums_nxt.green = sums_nxt.green + rbb_pkg::SUM_W'(win_r[i][j].green);
        sums_nxt.blue  = sums_nxt.blue  + rbb_pkg::SUM_W'(win_r[i][j].blue);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sums_r   <= sums_nxt;
      center_r <= win_r[1][1];
    end
  end

endmodule

@@ bench/region_box_blur_3x3_test.sv @@
// Self-checking testbench for region_box_blur_3x3: random stream traffic against a window predictor.
module region_box_blur_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rbb_pkg::*;

  localparam int BOX_CELLS = 9;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]       pad;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    pixel_t           px;
  } out_word_t;

  typedef struct packed {
    logic      blurred;
    logic      frame_end;
    out_word_t word;
  } blur_result_t;

  class blur_scoreboard;
    logic [CFG_DIM_W-1:0]  width_reg, height_reg;
    logic [CFG_POS_W-1:0]  ctr_col, ctr_row;
    logic [CFG_HALF_W-1:0] half_steps;
    pixel_t                line_upper [MAX_WIDTH];
    pixel_t                line_lower [MAX_WIDTH];
    pixel_t                win [3][3];
    int                    col_cnt, row_cnt;
    blur_result_t          awaited_pixels[$];
    int                    mismatches, checked, blurred_seen, frame_ends, inputs_seen;

    function new();
      width_reg  = CFG_DIM_W'(RST_WIDTH);
      height_reg = CFG_DIM_W'(RST_HEIGHT);
      ctr_col    = CFG_POS_W'(RST_CENTER);
      ctr_row    = CFG_POS_W'(RST_CENTER);
      half_steps = CFG_HALF_W'(RST_HALF);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_upper[i] = '0;
        line_lower[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = value;
        REG_IMAGE_HEIGHT: height_reg = value;
        REG_CENTER_COL:   ctr_col    = value[CFG_POS_W-1:0];
        REG_CENTER_ROW:   ctr_row    = value[CFG_POS_W-1:0];
        REG_HALF_SIZE:    half_steps = value[CFG_HALF_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_dim(logic [CFG_DIM_W-1:0] v, int limit);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > limit) return limit;
      return int'(v);
    endfunction

    function pixel_t window_mean();
      int     sr, sg, sb;
      pixel_t m;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          sr += win[i][j].red;
          sg += win[i][j].green;
          sb += win[i][j].blue;
        end
      m.red   = CH_W'(sr / BOX_CELLS);
      m.green = CH_W'(sg / BOX_CELLS);
      m.blue  = CH_W'(sb / BOX_CELLS);
      return m;
    endfunction

    function int pending();
      return awaited_pixels.size();
    endfunction

    function void note_input(opcode_e op, logic fs, pixel_t data);
      int           w, h, c, r, ex, ey, span, left, top, right, bottom;
      pixel_t       pix, up, lo;
      logic         blur;
      blur_result_t res;
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      inputs_seen++;
      pix = '0;
      if (op == OP_PIXEL) begin
        pix = data;
        if (fs) begin
          col_cnt = 0;
          row_cnt = 0;
        end
      end
      c = col_cnt;
      r = row_cnt;
      up = '0;
      lo = '0;
      if (c < MAX_WIDTH) begin
        up = line_upper[c];
        lo = line_lower[c];
        line_upper[c] = lo;
        line_lower[c] = pix;
      end
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = pix;
      if (c >= 1) begin
        ex = c - 1;
        ey = r - 1;
      end else begin
        ex = w - 1;
        ey = r - 2;
      end
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        if (row_cnt < h + 2) row_cnt++;
      end
      if (ey < 0 || ey >= h) return;
      span   = int'(half_steps) * STEP_PIXELS;
      left   = int'(ctr_col) - span;
      top    = int'(ctr_row) - span;
      right  = int'(ctr_col) + span;
      bottom = int'(ctr_row) + span;
      if (left < 0) left = 0;
      if (top < 0) top = 0;
      if (right > w - 1) right = w - 1;
      if (bottom > h - 1) bottom = h - 1;
      blur = ex >= 1 && ey >= 1 && ex >= left && ey >= top &&
             ex + 1 <= right && ey + 1 <= bottom;
      res.word.pad = '0;
      res.word.row = POS_W'(ey);
      res.word.col = POS_W'(ex);
      res.word.px  = blur ? window_mean() : win[1][1];
      res.blurred   = blur;
      res.frame_end = (ex == w - 1 && ey == h - 1);
      awaited_pixels.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last,
                               logic [OUT_TUSER_W-1:0] user);
      blur_result_t want;
      out_word_t    got;
      got = data;
      if (awaited_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel col %0d row %0d rgb %h blur %b end %b",
                   $time, got.col, got.row, got.px, user[0], last);
        return;
      end
      want = awaited_pixels.pop_front();
      checked++;
      if (got !== want.word || last !== want.frame_end || user[0] !== want.blurred) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: mismatch: expected col %0d row %0d rgb %h blur %b end %b, ",
                    "got col %0d row %0d rgb %h blur %b end %b pad %b"},
                   $time, want.word.col, want.word.row, want.word.px, want.blurred,
                   want.frame_end, got.col, got.row, got.px, user[0], last, got.pad);
      end else begin
        if (want.blurred) blurred_seen++;
        if (want.frame_end) frame_ends++;
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  bit             steady = 1'b0;
  int             pixels_sent = 0;
  int             settings_used = 0;
  blur_scoreboard board;

  region_box_blur_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast, out_tuser);
  end

  function automatic pixel_t rand_pixel();
    pixel_t p;
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_item(opcode_e op, logic fs, pixel_t pix);
    while (!steady && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= {fs, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(op, fs, pix);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.apply_config(idx, value);
  endtask

  // idle the stream, collect every awaited pixel, let non-emitting items leave the pipe
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] cc, logic [CFG_DATA_W-1:0] cr,
                           logic [CFG_DATA_W-1:0] hs);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CENTER_COL, cc);
    write_reg(REG_CENTER_ROW, cr);
    write_reg(REG_HALF_SIZE, hs);
    if ($urandom_range(3) == 0)
      write_reg(REG_HALF_SIZE + CFG_IDX_W'($urandom_range(3, 1)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_frame(int w, int h, bit noisy);
    int stop_at, sent, tail;
    stop_at = w * h;
    if (noisy && $urandom_range(5) == 0) stop_at = $urandom_range(w * h - 1, 1);
    sent = 0;
    for (int y = 0; y < h && sent < stop_at; y++)
      for (int x = 0; x < w && sent < stop_at; x++) begin
        if (noisy && $urandom_range(40) == 0)
          send_item(OP_DRAIN, 1'($urandom_range(1)), rand_pixel());
        send_item(OP_PIXEL, (x == 0 && y == 0) || (noisy && $urandom_range(60) == 0),
                  rand_pixel());
        sent++;
        pixels_sent++;
      end
    tail = w + 1;
    if (noisy) tail = tail + $urandom_range(3) - 1;
    repeat (tail) send_item(OP_DRAIN, 1'($urandom_range(1)), rand_pixel());
    if (noisy && $urandom_range(3) == 0)
      repeat (2) send_item(OP_PIXEL, 1'b0, rand_pixel());
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w_code, h_code, hs_code, cc, cr;
    int                    w_eff, h_eff, span, edge_pos, phase;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame: single blurred center, extreme channel values, then tail flush
    configure(12'd3, 12'd3, 12'd1, 12'd1, 12'd1);
    send_item(OP_PIXEL, 1'b1, 24'h000000);
    send_item(OP_PIXEL, 1'b0, 24'hffffff);
    send_item(OP_PIXEL, 1'b0, 24'hff00ff);
    send_item(OP_PIXEL, 1'b0, 24'h00ff00);
    send_item(OP_PIXEL, 1'b0, 24'hffffff);
    send_item(OP_PIXEL, 1'b0, 24'hffffff);
    send_item(OP_PIXEL, 1'b0, 24'h0000ff);
    send_item(OP_PIXEL, 1'b0, 24'hffff00);
    send_item(OP_PIXEL, 1'b0, 24'hffffff);
    send_item(OP_DRAIN, 1'b1, 24'hffffff);
    repeat (3) send_item(OP_DRAIN, 1'b0, 24'h000000);
    // past the frame: nothing comes out
    repeat (2) send_item(OP_DRAIN, 1'b0, 24'h000000);
    send_item(OP_PIXEL, 1'b0, 24'h00ff00);
    // restart in the middle of nowhere
    send_item(OP_PIXEL, 1'b1, 24'h800001);
    send_item(OP_PIXEL, 1'b0, 24'h7ffffe);
    send_item(OP_PIXEL, 1'b0, 24'h55aa55);

    phase = 0;
    while (pixels_sent < 350) begin
      phase++;
      w_code  = ($urandom_range(9) == 0) ? 12'($urandom_range(2)) : 12'($urandom_range(12, 3));
      h_code  = ($urandom_range(9) == 0) ? 12'($urandom_range(2)) : 12'($urandom_range(8, 3));
      w_eff   = (w_code < MIN_DIM) ? MIN_DIM : int'(w_code);
      h_eff   = (h_code < MIN_DIM) ? MIN_DIM : int'(h_code);
      hs_code = ($urandom_range(6) == 0) ? 12'($urandom_range(7)) : 12'($urandom_range(5, 1));
      span    = int'(hs_code[CFG_HALF_W-1:0]) * STEP_PIXELS;
      if ($urandom_range(4) == 0) hs_code = hs_code | (12'($urandom) & 12'hff8);
      case ($urandom_range(5))
        0: cc = 12'($urandom);
        1: cc = '0;
        default: begin
          edge_pos = $urandom_range(w_eff + 1);
          cc = ($urandom_range(1) && edge_pos >= span) ? 12'(edge_pos - span)
                                                       : 12'(edge_pos + span);
        end
      endcase
      case ($urandom_range(5))
        0: cr = 12'($urandom);
        1: cr = '0;
        default: begin
          edge_pos = $urandom_range(h_eff + 1);
          cr = ($urandom_range(1) && edge_pos >= span) ? 12'(edge_pos - span)
                                                       : 12'(edge_pos + span);
        end
      endcase
      steady = (phase == 3);
      configure(w_code, h_code, cc, cr, hs_code);
      repeat ($urandom_range(2, 1)) run_frame(w_eff, h_eff, $urandom_range(3) != 0);
    end

    // region against the right and bottom edges, half size past the image
    steady = 1'b1;
    configure(12'd12, 12'd8, 12'd11, 12'd7, 12'd7);
    run_frame(12, 8, 1'b0);
    steady = 1'b0;
    // clamped dimensions, one-pixel region
    configure(12'd1, 12'd2, 12'd1, 12'd1, 12'd0);
    run_frame(MIN_DIM, MIN_DIM, 1'b0);

    settle();
    $display("Checked %0d pixels (%0d blurred, %0d frame ends) from %0d input transactions",
             board.checked, board.blurred_seen, board.frame_ends, board.inputs_seen);
    $display("over %0d register settings; %0d mismatches, %0d pixels still awaited",
             settings_used, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d pixels still awaited", board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
